// ----- sv/solid_sdf_phi_velocity_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the solid distance and velocity block
// Shared checks, clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SOLID_SDF_PHI_VELOCITY_DEFINES_SVH
`define SOLID_SDF_PHI_VELOCITY_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define SSPV_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sspv: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SSPV_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sspv: same-cycle check failed");

`endif

// ----- sv/sspv_pkg.sv -----
// ----------------------------------------------------------------------------
// sspv_pkg
// Types, constants and helpers shared by the solid distance pipeline.
// ----------------------------------------------------------------------------
package sspv_pkg;

  localparam int OFS_W     = 30;  // clamped offset, +-2^28
  localparam int CLAMP_W   = 40;  // width fed to the offset clamp
  localparam int QUAT_W    = 16;
  localparam int QUAT_FRAC = 14;
  localparam int M_W       = 34;  // rotation matrix entry
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int SQ_W      = 58;  // sum of three squares
  localparam int ROOT_W    = 29;
  localparam int BOXM_W    = 34;  // inner box term, signed

  localparam logic signed [CLAMP_W-1:0] OFS_LIM = 40'sd268435456;

  typedef enum logic [1:0] {
    SHAPE_BOX     = 2'd0,
    SHAPE_SPHERE  = 2'd1,
    SHAPE_CAPSULE = 2'd2,
    SHAPE_NONE    = 2'd3
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_KIND  = 3'd0,
    REG_INSIDE_FLAG = 3'd1,
    REG_CENTER      = 3'd2,
    REG_SIZE        = 3'd3,
    REG_ROUNDING    = 3'd4,
    REG_QUAT        = 3'd5,
    REG_LIN_VEL     = 3'd6,
    REG_ANG_VEL     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    shape_t       kind;
    logic         negate;
    logic [59:0]  center;
    logic [59:0]  size;
    logic [18:0]  rounding;
    logic [63:0]  quat;
    logic [59:0]  lin_vel;
    logic [59:0]  ang_vel;
  } cfg_t;

  // Clamp an offset to +-2^28.
  function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [CLAMP_W-1:0] v);
    logic signed [OFS_W-1:0] res;
    if (v > OFS_LIM) res = OFS_W'(OFS_LIM);
    else if (v < -OFS_LIM) res = OFS_W'(-OFS_LIM);
    else res = OFS_W'(v);
    return res;
  endfunction

  // Saturate to the 24-bit output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > 64'sd8388607) res = 24'sh7fffff;
    else if (v < -64'sd8388608) res = 24'sh800000;
    else res = OUT_W'(v);
    return res;
  endfunction

endpackage

// ----- sv/sspv_xform.sv -----
// ----------------------------------------------------------------------------
// sspv_xform
// Stages 1-3: offset from centre, rotation by the conjugate quaternion,
// and rigid-body velocity at the point.
// ----------------------------------------------------------------------------
module sspv_xform #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [COORD_BITS-1:0]           pos_x,
  input  logic signed [COORD_BITS-1:0]           pos_y,
  input  logic signed [COORD_BITS-1:0]           pos_z,
  input  sspv_pkg::cfg_t                         cfg,
  output logic                                   out_vld,
  output logic signed [sspv_pkg::OFS_W-1:0]      rot [3],
  output logic signed [sspv_pkg::OFS_W-1:0]      ofs [3],
  output logic signed [sspv_pkg::OUT_W-1:0]      vel [3]
);

  localparam int CW = COORD_BITS;
  localparam int OW = sspv_pkg::OFS_W;
  localparam int MW = sspv_pkg::M_W;
  localparam int RSH = 2 * sspv_pkg::QUAT_FRAC;

  logic [63:0] ctr64, lin64, ang64;
  logic signed [CW-1:0] pos [3];
  logic signed [CW-1:0] cen [3];
  logic signed [CW-1:0] lin [3];
  logic signed [CW-1:0] ang [3];
  logic signed [sspv_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [MW-1:0] mat [3][3];

  logic vld1, vld2;
  logic signed [OW-1:0] d1 [3];
  logic signed [OW-1:0] d2 [3];
  logic signed [MW-1:0] m1 [3][3];
  logic signed [63:0] pr [3][3];
  logic signed [63:0] pa [3];
  logic signed [63:0] pb [3];

  assign ctr64 = {4'b0, cfg.center};
  assign lin64 = {4'b0, cfg.lin_vel};
  assign ang64 = {4'b0, cfg.ang_vel};
  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // Unpack per-axis config fields; fields past bit 63 read as zero
  for (genvar i = 0; i < 3; i++) begin : g_fld
    assign cen[i] = CW'(ctr64 >> (i * CW));
    assign lin[i] = CW'(lin64 >> (i * CW));
    assign ang[i] = CW'(ang64 >> (i * CW));
  end

  assign qw = cfg.quat[15:0];
  assign qx = cfg.quat[31:16];
  assign qy = cfg.quat[47:32];
  assign qz = cfg.quat[63:48];

  // Build the transposed rotation matrix
  always_comb begin
    ww = qw * qw;  xx = qx * qx;  yy = qy * qy;  zz = qz * qz;
    xy = qx * qy;  wz = qw * qz;  xz = qx * qz;
    wy = qw * qy;  yz = qy * qz;  wx = qw * qx;
    mat[0][0] = MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
    mat[1][1] = MW'(ww) - MW'(xx) + MW'(yy) - MW'(zz);
    mat[2][2] = MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
    mat[0][1] = (MW'(xy) + MW'(wz)) <<< 1;
    mat[0][2] = (MW'(xz) - MW'(wy)) <<< 1;
    mat[1][0] = (MW'(xy) - MW'(wz)) <<< 1;
    mat[1][2] = (MW'(yz) + MW'(wx)) <<< 1;
    mat[2][0] = (MW'(xz) + MW'(wy)) <<< 1;
    mat[2][1] = (MW'(yz) - MW'(wx)) <<< 1;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ax
    logic signed [sspv_pkg::CLAMP_W-1:0] diff;
    logic signed [65:0] rsum;
    logic signed [65:0] rsh;
    logic signed [63:0] vsum;
    logic signed [63:0] vsh;

    assign diff = sspv_pkg::CLAMP_W'(pos[i]) - sspv_pkg::CLAMP_W'(cen[i]);
    assign rsum = 66'(pr[i][0]) + 66'(pr[i][1]) + 66'(pr[i][2]);
    assign rsh  = (rsum + (66'sd1 <<< (RSH - 1))) >>> RSH;
    assign vsum = (64'(lin[i]) <<< FRAC_BITS) + pa[i] - pb[i];
    assign vsh  = (vsum + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    // Stage 1: clamped offset and matrix row
    always_ff @(posedge clk) begin
      if (en) begin
        d1[i] <= sspv_pkg::clamp_ofs(diff);
        for (int j = 0; j < 3; j++) m1[i][j] <= mat[i][j];
      end
    end

    // Stage 2: matrix and cross products
    always_ff @(posedge clk) begin
      if (en) begin
        d2[i] <= d1[i];
        for (int j = 0; j < 3; j++) pr[i][j] <= m1[i][j] * d1[j];
        pa[i] <= ang[(i + 1) % 3] * d1[(i + 2) % 3];
        pb[i] <= ang[(i + 2) % 3] * d1[(i + 1) % 3];
      end
    end

    // Stage 3: round, clamp and saturate
    always_ff @(posedge clk) begin
      if (en) begin
        ofs[i] <= d2[i];
        rot[i] <= sspv_pkg::clamp_ofs(sspv_pkg::CLAMP_W'(rsh));
        vel[i] <= sspv_pkg::sat_out(vsh);
      end
    end
  end

endmodule

// ----- sv/sspv_shape.sv -----
// ----------------------------------------------------------------------------
// sspv_shape
// Stages 4-6: per-shape residual vector, squares, and their sum.
// ----------------------------------------------------------------------------
module sspv_shape #(
  parameter int COORD_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic signed [sspv_pkg::OFS_W-1:0]     rot [3],
  input  logic signed [sspv_pkg::OFS_W-1:0]     ofs [3],
  input  logic signed [sspv_pkg::OUT_W-1:0]     vel_in [3],
  input  sspv_pkg::cfg_t                        cfg,
  output logic                                  out_vld,
  output logic [sspv_pkg::SQ_W-1:0]             sq_sum,
  output logic signed [sspv_pkg::BOXM_W-1:0]    boxm,
  output logic signed [sspv_pkg::OUT_W-1:0]     vel [3]
);

  localparam int CW = COORD_BITS;
  localparam int OW = sspv_pkg::OFS_W;
  localparam int BW = sspv_pkg::BOXM_W;
  localparam int SW = sspv_pkg::SQ_W;

  logic [63:0] size64;
  logic [CW-1:0] sz [3];
  logic signed [BW-1:0] e [3];
  logic signed [OW-1:0] epos [3];
  logic signed [BW-1:0] emax, boxm_c;
  logic signed [35:0] r0e, len, xcap;
  logic signed [OW-1:0] comp_c [3];

  logic vld4, vld5;
  logic signed [OW-1:0] comp [3];
  logic [SW-1:0] sq [3];
  logic signed [BW-1:0] boxm4, boxm5;
  logic signed [sspv_pkg::OUT_W-1:0] vel4 [3];
  logic signed [sspv_pkg::OUT_W-1:0] vel5 [3];

  assign size64 = {4'b0, cfg.size};

  for (genvar i = 0; i < 3; i++) begin : g_ext
    logic signed [OW-1:0] absr;
    assign sz[i]   = CW'(size64 >> (i * CW));
    assign absr    = rot[i][OW-1] ? -rot[i] : rot[i];
    assign e[i]    = BW'(absr) - BW'(sz[i]);
    assign epos[i] = (e[i] > 0) ? OW'(e[i]) : '0;
  end

  // Pick the residual vector for the shape
  always_comb begin
    emax   = (e[0] > e[1]) ? e[0] : e[1];
    emax   = (emax > e[2]) ? emax : e[2];
    boxm_c = (emax > 0) ? '0 : emax;
    r0e    = 36'(rot[0]);
    len    = $signed(36'(sz[1]));
    if (r0e > len) xcap = r0e - len;
    else if (r0e < -len) xcap = r0e + len;
    else xcap = '0;
    unique case (cfg.kind)
      sspv_pkg::SHAPE_BOX: begin
        comp_c = epos;
      end
      sspv_pkg::SHAPE_SPHERE: begin
        comp_c = ofs;
      end
      sspv_pkg::SHAPE_CAPSULE: begin
        comp_c[0] = sspv_pkg::clamp_ofs(sspv_pkg::CLAMP_W'(xcap));
        comp_c[1] = rot[1];
        comp_c[2] = rot[2];
      end
      sspv_pkg::SHAPE_NONE: begin
        comp_c = '{default: '0};
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4    <= 1'b0;
      vld5    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld4    <= in_vld;
      vld5    <= vld4;
      out_vld <= vld5;
    end
  end

  // Stages 4, 5, 6: residual, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      comp   <= comp_c;
      boxm4  <= boxm_c;
      vel4   <= vel_in;
      for (int i = 0; i < 3; i++) sq[i] <= SW'(comp[i] * comp[i]);
      boxm5  <= boxm4;
      vel5   <= vel4;
      sq_sum <= sq[0] + sq[1] + sq[2];
      boxm   <= boxm5;
      vel    <= vel5;
    end
  end

endmodule

// ----- sv/sspv_isqrt.sv -----
// ----------------------------------------------------------------------------
// sspv_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sspv_isqrt #(
  parameter int IN_W   = 58,
  parameter int ROOT_W = 29,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  logic [IN_W-1:0]   rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [SIDE_W-1:0] side_q [ROOT_W+1];
  logic [ROOT_W:0]   vld_q;

  assign rem_q[0]  = radicand;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;
  assign vld_q[0]  = in_vld;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    localparam int B = ROOT_W - 1 - k;
    logic [IN_W-1:0] trial;
    logic            take;

    assign trial = (IN_W'(root_q[k]) << (B + 1)) | (IN_W'(1) << (2 * B));
    assign take  = rem_q[k] >= trial;

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    // Try one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= take ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= take ? root_q[k] | (ROOT_W'(1) << B) : root_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_vld  = vld_q[ROOT_W];
  assign root     = root_q[ROOT_W];
  assign side_out = side_q[ROOT_W];

endmodule

// ----- sv/solid_sdf_phi_velocity.sv -----
// ----------------------------------------------------------------------------
// solid_sdf_phi_velocity
// Signed distance to one configured rigid solid and its velocity at a point.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir
//  request | in_valid, in_ready, pos_x/y/z         | in
//  result  | out_valid, out_ready, distance, vel_* | out
//  config  | cfg_wr_en, cfg_index, cfg_data        | in
//
//  There are 36 register stages: 3 transform, 3 shape, 29 square-root, 1 output.
//  One request per cycle is accepted while no result waits at the output;
//  the square-root bit stages set the depth. All stages advance together;
//  an unaccepted result stalls the whole pipe. Reset clears the valid bits
//  and loads the config defaults.
// ----------------------------------------------------------------------------
`include "solid_sdf_phi_velocity_defines.svh"

module solid_sdf_phi_velocity #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_BITS-1:0]           pos_x,
  input  logic signed [COORD_BITS-1:0]           pos_y,
  input  logic signed [COORD_BITS-1:0]           pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sspv_pkg::OUT_W-1:0]      distance,
  output logic signed [sspv_pkg::OUT_W-1:0]      vel_x,
  output logic signed [sspv_pkg::OUT_W-1:0]      vel_y,
  output logic signed [sspv_pkg::OUT_W-1:0]      vel_z,
  input  logic                                   cfg_wr_en,
  input  logic [sspv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sspv_pkg::CFG_W-1:0]             cfg_data
);

  localparam int OW   = sspv_pkg::OFS_W;
  localparam int VW   = sspv_pkg::OUT_W;
  localparam int BW   = sspv_pkg::BOXM_W;
  localparam int SIDE = BW + 3 * VW;

  sspv_pkg::cfg_t cfg;
  logic en;

  logic x_vld, s_vld, sq_vld;
  logic signed [OW-1:0] rot [3];
  logic signed [OW-1:0] ofs [3];
  logic signed [VW-1:0] vel3 [3];
  logic signed [VW-1:0] vel6 [3];
  logic [sspv_pkg::SQ_W-1:0] sq_sum;
  logic signed [BW-1:0] boxm;
  logic [sspv_pkg::ROOT_W-1:0] sq_root;
  logic [SIDE-1:0] side_in, side_out;
  logic signed [BW-1:0] boxm_f;
  logic [63:0] size64;
  logic [COORD_BITS-1:0] s0;
  logic signed [39:0] phi, phi_n;

  // Global advance: hold everything while a result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind     <= sspv_pkg::SHAPE_NONE;
      cfg.negate   <= 1'b0;
      cfg.center   <= '0;
      cfg.size     <= '0;
      cfg.rounding <= '0;
      cfg.quat     <= 64'd16384;
      cfg.lin_vel  <= '0;
      cfg.ang_vel  <= '0;
    end else if (cfg_wr_en) begin
      unique case (sspv_pkg::cfg_idx_t'(cfg_index))
        sspv_pkg::REG_SHAPE_KIND:  cfg.kind     <= sspv_pkg::shape_t'(cfg_data[1:0]);
        sspv_pkg::REG_INSIDE_FLAG: cfg.negate   <= cfg_data[0];
        sspv_pkg::REG_CENTER:      cfg.center   <= cfg_data[59:0];
        sspv_pkg::REG_SIZE:        cfg.size     <= cfg_data[59:0];
        sspv_pkg::REG_ROUNDING:    cfg.rounding <= cfg_data[18:0];
        sspv_pkg::REG_QUAT:        cfg.quat     <= cfg_data;
        sspv_pkg::REG_LIN_VEL:     cfg.lin_vel  <= cfg_data[59:0];
        sspv_pkg::REG_ANG_VEL:     cfg.ang_vel  <= cfg_data[59:0];
      endcase
    end
  end

  sspv_xform #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid && in_ready),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z),
    .cfg    (cfg),
    .out_vld(x_vld),
    .rot    (rot),
    .ofs    (ofs),
    .vel    (vel3)
  );

  sspv_shape #(
    .COORD_BITS(COORD_BITS)
  ) u_shape (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (x_vld),
    .rot    (rot),
    .ofs    (ofs),
    .vel_in (vel3),
    .cfg    (cfg),
    .out_vld(s_vld),
    .sq_sum (sq_sum),
    .boxm   (boxm),
    .vel    (vel6)
  );

  assign side_in = {boxm, vel6[0], vel6[1], vel6[2]};

  sspv_isqrt #(
    .IN_W  (sspv_pkg::SQ_W),
    .ROOT_W(sspv_pkg::ROOT_W),
    .SIDE_W(SIDE)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_vld),
    .radicand(sq_sum),
    .side_in (side_in),
    .out_vld (sq_vld),
    .root    (sq_root),
    .side_out(side_out)
  );

  assign boxm_f = side_out[SIDE-1 -: BW];
  assign size64 = {4'b0, cfg.size};
  assign s0     = COORD_BITS'(size64);

  // Combine root with the shape terms, then negate for inside
  always_comb begin
    unique case (cfg.kind)
      sspv_pkg::SHAPE_BOX:
        phi = 40'(boxm_f) + 40'(sq_root) - 40'(cfg.rounding);
      sspv_pkg::SHAPE_SPHERE, sspv_pkg::SHAPE_CAPSULE:
        phi = 40'(sq_root) - 40'(s0);
      sspv_pkg::SHAPE_NONE:
        phi = '0;
    endcase
    phi_n = cfg.negate ? -phi : phi;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance <= sspv_pkg::sat_out(64'(phi_n));
      vel_x    <= side_out[3*VW-1 -: VW];
      vel_y    <= side_out[2*VW-1 -: VW];
      vel_z    <= side_out[VW-1 -: VW];
    end
  end

  `SSPV_ASSERT_NEXT(a_stall_holds_root, clk, rst, out_valid && !out_ready, $stable(sq_root) && $stable(sq_vld))
  `SSPV_ASSERT_SAME(a_full_blocks_input, clk, rst, out_valid && !out_ready, !in_ready)
  `SSPV_ASSERT_SAME(a_result_from_root, clk, rst, $rose(out_valid), $past(sq_vld))

endmodule

// ----- tb/sv/sspv_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sspv_checker
// Watches the request, result and register ports of the solid distance
// block, keeps its own copy of the registers, computes each expected result
// and compares arriving results in order, field by field.
// ----------------------------------------------------------------------------
module sspv_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [19:0] pos_x,
  input  logic signed [19:0] pos_y,
  input  logic signed [19:0] pos_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] distance,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_y,
  input  logic signed [23:0] vel_z,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [23:0] phi;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
  } solid_sample_t;

  localparam longint OFS_MAX = 64'sd268435456;

  sspv_pkg::cfg_t regs;
  solid_sample_t  sample_q[$];

  function automatic longint coord(input logic [59:0] packed_v, input int i);
    logic signed [19:0] t;
    t = packed_v[i*20 +: 20];
    return t;
  endfunction

  function automatic longint clip_ofs(input longint v);
    if (v > OFS_MAX) return OFS_MAX;
    if (v < -OFS_MAX) return -OFS_MAX;
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Floor square root of the sum of three squares
  function automatic longint root3(input longint a, input longint b, input longint c);
    longint unsigned v, r, bit_v;
    v = a * a + b * b + c * c;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint max2(input longint a, input longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint abs2(input longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic solid_sample_t solid_at(input logic signed [19:0] px,
                                             input logic signed [19:0] py,
                                             input logic signed [19:0] pz);
    longint d[3], r[3], w[3], v[3], s[3], e[3];
    longint qw, qx, qy, qz, m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint phi, m, x, fvx, fvy, fvz;
    logic signed [15:0] qf;
    solid_sample_t res;
    d[0] = clip_ofs(longint'(px) - coord(regs.center, 0));
    d[1] = clip_ofs(longint'(py) - coord(regs.center, 1));
    d[2] = clip_ofs(longint'(pz) - coord(regs.center, 2));
    for (int i = 0; i < 3; i++) begin
      w[i] = coord(regs.ang_vel, i);
      v[i] = coord(regs.lin_vel, i);
      s[i] = longint'(regs.size[i*20 +: 20]);
    end
    qf = regs.quat[15:0];  qw = qf;
    qf = regs.quat[31:16]; qx = qf;
    qf = regs.quat[47:32]; qy = qf;
    qf = regs.quat[63:48]; qz = qf;

    // Rotate the offset by the conjugate orientation
    m00 = qw*qw + qx*qx - qy*qy - qz*qz;
    m11 = qw*qw - qx*qx + qy*qy - qz*qz;
    m22 = qw*qw - qx*qx - qy*qy + qz*qz;
    m01 = 2 * (qx*qy + qw*qz);
    m02 = 2 * (qx*qz - qw*qy);
    m10 = 2 * (qx*qy - qw*qz);
    m12 = 2 * (qy*qz + qw*qx);
    m20 = 2 * (qx*qz + qw*qy);
    m21 = 2 * (qy*qz - qw*qx);
    r[0] = clip_ofs(rnd_shift(m00*d[0] + m01*d[1] + m02*d[2], 2*sspv_pkg::QUAT_FRAC));
    r[1] = clip_ofs(rnd_shift(m10*d[0] + m11*d[1] + m12*d[2], 2*sspv_pkg::QUAT_FRAC));
    r[2] = clip_ofs(rnd_shift(m20*d[0] + m21*d[1] + m22*d[2], 2*sspv_pkg::QUAT_FRAC));

    case (regs.kind)
      sspv_pkg::SHAPE_BOX: begin
        for (int i = 0; i < 3; i++) e[i] = abs2(r[i]) - s[i];
        m = max2(max2(e[0], e[1]), e[2]);
        if (m > 0) m = 0;
        phi = m + root3(max2(e[0], 0), max2(e[1], 0), max2(e[2], 0))
            - longint'(regs.rounding);
      end
      sspv_pkg::SHAPE_SPHERE: phi = root3(d[0], d[1], d[2]) - s[0];
      sspv_pkg::SHAPE_CAPSULE: begin
        if (r[0] > s[1]) x = r[0] - s[1];
        else if (r[0] < -s[1]) x = r[0] + s[1];
        else x = 0;
        phi = root3(clip_ofs(x), r[1], r[2]) - s[0];
      end
      default: phi = 0;
    endcase
    if (regs.negate) phi = -phi;

    // Rigid body velocity at the offset
    fvx = v[0] * 1024 + w[1]*d[2] - w[2]*d[1];
    fvy = v[1] * 1024 + w[2]*d[0] - w[0]*d[2];
    fvz = v[2] * 1024 + w[0]*d[1] - w[1]*d[0];
    res.phi = sat24(phi);
    res.vx  = sat24(rnd_shift(fvx, 10));
    res.vy  = sat24(rnd_shift(fvy, 10));
    res.vz  = sat24(rnd_shift(fvz, 10));
    return res;
  endfunction

  always @(posedge clk) begin
    solid_sample_t exp_s;
    if (rst) begin
      regs.kind     <= sspv_pkg::SHAPE_NONE;
      regs.negate   <= 1'b0;
      regs.center   <= '0;
      regs.size     <= '0;
      regs.rounding <= '0;
      regs.quat     <= 64'd16384;
      regs.lin_vel  <= '0;
      regs.ang_vel  <= '0;
      sample_q.delete();
      errors <= 0;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (sspv_pkg::cfg_idx_t'(cfg_index))
          sspv_pkg::REG_SHAPE_KIND:  regs.kind     <= sspv_pkg::shape_t'(cfg_data[1:0]);
          sspv_pkg::REG_INSIDE_FLAG: regs.negate   <= cfg_data[0];
          sspv_pkg::REG_CENTER:      regs.center   <= cfg_data[59:0];
          sspv_pkg::REG_SIZE:        regs.size     <= cfg_data[59:0];
          sspv_pkg::REG_ROUNDING:    regs.rounding <= cfg_data[18:0];
          sspv_pkg::REG_QUAT:        regs.quat     <= cfg_data;
          sspv_pkg::REG_LIN_VEL:     regs.lin_vel  <= cfg_data[59:0];
          sspv_pkg::REG_ANG_VEL:     regs.ang_vel  <= cfg_data[59:0];
          default: ;
        endcase
      end
      // Predict each accepted request
      if (in_valid && in_ready)
        sample_q.insert(sample_q.size(), solid_at(pos_x, pos_y, pos_z));
      // Compare each accepted result against the oldest prediction
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          exp_s = sample_q.pop_front();
          if (distance !== exp_s.phi || vel_x !== exp_s.vx ||
              vel_y !== exp_s.vy || vel_z !== exp_s.vz) begin
            errors <= errors + 1;
            if (distance !== exp_s.phi)
              $error("distance expected %0d actual %0d", exp_s.phi, distance);
            if (vel_x !== exp_s.vx)
              $error("vel_x expected %0d actual %0d", exp_s.vx, vel_x);
            if (vel_y !== exp_s.vy)
              $error("vel_y expected %0d actual %0d", exp_s.vy, vel_y);
            if (vel_z !== exp_s.vz)
              $error("vel_z expected %0d actual %0d", exp_s.vz, vel_z);
          end
        end
      end
    end
    // Publish the number of outstanding requests
    pending <= sample_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the solid distance block through a series of register settings,
// each followed by directed (phases 0-2) and random query points with bursty
// requests, a stalling result side; checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PHASES   = 12;
  localparam int PER_PHASE = 84;
  localparam int DRAIN    = 60;
  localparam int LIMIT    = 400000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [19:0] pos_x, pos_y, pos_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] distance, vel_x, vel_y, vel_z;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic [59:0]        cur_center;

  always #6 clk = ~clk;

  solid_sdf_phi_velocity dut (.*);

  sspv_checker chk (.*);

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side stalls in modes that change every so often
  always @(posedge clk) begin
    int mode;
    if (cycles % 97 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycles % 8) < 5);
    endcase
  end

  task automatic write_reg(input sspv_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  function automatic logic [59:0] rand60();
    return 60'({$urandom(), $urandom()});
  endfunction

  // Small sizes packed into three 20-bit fields
  function automatic logic [59:0] rand_sizes();
    return {20'($urandom_range(0, 20000)), 20'($urandom_range(0, 20000)),
            20'($urandom_range(0, 20000))};
  endfunction

  // Unit-ish quaternion, or a raw one now and then
  function automatic logic [63:0] rand_quat();
    case ($urandom_range(0, 3))
      0: return {$urandom(), $urandom()};
      1: return 64'd16384;
      default: return {16'($signed($urandom_range(0, 16384)) - 8192),
                       16'($signed($urandom_range(0, 16384)) - 8192),
                       16'($signed($urandom_range(0, 16384)) - 8192),
                       16'($urandom_range(8192, 16384))};
    endcase
  endfunction

  task automatic load_phase(input int ph);
    logic [59:0]       cen;
    sspv_pkg::shape_t  kind;
    kind = sspv_pkg::shape_t'(ph % 4);
    case (ph)
      1: begin
        // All fields but the shape kind at their top
        cen = '1;
        write_reg(sspv_pkg::REG_SHAPE_KIND, 64'(kind));
        write_reg(sspv_pkg::REG_INSIDE_FLAG, 64'd1);
        write_reg(sspv_pkg::REG_CENTER, 64'(cen));
        write_reg(sspv_pkg::REG_SIZE, 64'(60'hfffffffffffffff));
        write_reg(sspv_pkg::REG_ROUNDING, 64'h7ffff);
        write_reg(sspv_pkg::REG_QUAT, 64'hffffffffffffffff);
        write_reg(sspv_pkg::REG_LIN_VEL, 64'(60'hfffffffffffffff));
        write_reg(sspv_pkg::REG_ANG_VEL, 64'(60'h7ffff7ffff7ffff));
      end
      2: begin
        // Zero quaternion, most negative center and velocities
        cen = {3{20'h80000}};
        write_reg(sspv_pkg::REG_SHAPE_KIND, 64'(kind));
        write_reg(sspv_pkg::REG_INSIDE_FLAG, 64'd0);
        write_reg(sspv_pkg::REG_CENTER, 64'(cen));
        write_reg(sspv_pkg::REG_SIZE, 64'd0);
        write_reg(sspv_pkg::REG_ROUNDING, 64'd0);
        write_reg(sspv_pkg::REG_QUAT, 64'd0);
        write_reg(sspv_pkg::REG_LIN_VEL, 64'(cen));
        write_reg(sspv_pkg::REG_ANG_VEL, 64'(cen));
      end
      default: begin
        cen = {20'($signed($urandom_range(0, 8000)) - 4000),
               20'($signed($urandom_range(0, 8000)) - 4000),
               20'($signed($urandom_range(0, 8000)) - 4000)};
        write_reg(sspv_pkg::REG_SHAPE_KIND, 64'(kind));
        write_reg(sspv_pkg::REG_INSIDE_FLAG, 64'($urandom_range(0, 1)));
        write_reg(sspv_pkg::REG_CENTER, 64'(cen));
        // capsule with zero half length in phase 6
        write_reg(sspv_pkg::REG_SIZE, (kind == sspv_pkg::SHAPE_CAPSULE && ph == 6) ?
                  64'($urandom_range(1, 5000)) : 64'(rand_sizes()));
        write_reg(sspv_pkg::REG_ROUNDING, 64'($urandom_range(0, 3000)));
        write_reg(sspv_pkg::REG_QUAT, rand_quat());
        write_reg(sspv_pkg::REG_LIN_VEL,
                  ($urandom_range(0, 1) == 1) ? 64'(rand60()) : 64'd0);
        write_reg(sspv_pkg::REG_ANG_VEL, ($urandom_range(0, 3) == 0) ? 64'(rand60()) :
                  64'({20'($urandom_range(0, 63)), 20'($urandom_range(0, 63)),
                       20'($urandom_range(0, 63))}));
      end
    endcase
    cfg_wr_en <= 1'b0;
    cur_center = cen;
  endtask

  function automatic logic [19:0] rand_coord(input logic [19:0] c);
    case ($urandom_range(0, 9))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2, 3, 4, 5: return c + 20'($signed($urandom_range(0, 40000)) - 20000);
      default: return 20'($urandom());
    endcase
  endfunction

  // Present one request and hold it until taken
  task automatic send_point(input logic [19:0] x, input logic [19:0] y,
                            input logic [19:0] z);
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Let the count of outstanding requests settle, then wait for it to empty
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int burst;
    logic [19:0] ext[4];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    cur_center = '0;
    ext = '{20'h80000, 20'h7ffff, 20'h00000, 20'hfffff};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Phase zero runs on the reset settings
      if (ph != 0) load_phase(ph);
      // Extremes of the coordinates, then the center itself
      if (ph < 3) begin
        for (int i = 0; i < 8; i++)
          send_point(ext[i % 4], ext[(i + 1) % 4], ext[(i / 2) % 4]);
        send_point(cur_center[19:0], cur_center[39:20], cur_center[59:40]);
      end
      burst = $urandom_range(1, 20);
      for (int n = 0; n < PER_PHASE; n++) begin
        send_point(rand_coord(cur_center[19:0]), rand_coord(cur_center[39:20]),
                   rand_coord(cur_center[59:40]));
        if (n == PER_PHASE / 2) begin
          // Hold until the pipe empties
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end else if (--burst == 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
